>>> hdl/cstl_pkg.sv
// Package for the connection slot table: sizes, action and liveness codes,
// sequencer states and the slot entry layout. No dependencies.
`default_nettype none

package cstl_pkg;

	localparam int SLOT_COUNT = 15;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SOCK_W     = 8;
	localparam int TIME_W     = 32;
	localparam int BUDGET_W   = 16;
	localparam int COUNT_W    = 8;
	localparam int OUT_IDX_W  = 4;

	localparam logic [BUDGET_W-1:0] BUDGET_RESET  = BUDGET_W'(10 * 60);
	localparam logic [TIME_W-1:0]   MS_PER_SECOND = TIME_W'(1000);

	localparam logic [1:0] ACT_CONNECT    = 2'd0;
	localparam logic [1:0] ACT_MESSAGE    = 2'd1;
	localparam logic [1:0] ACT_DISCONNECT = 2'd2;
	localparam logic [1:0] ACT_PRUNE      = 2'd3;

	localparam logic [1:0] LIVE_INIT = 2'd0;
	localparam logic [1:0] LIVE_TEST = 2'd1;
	localparam logic [1:0] LIVE_OK   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LIMIT,
		ST_CHECK
	} cstl_state_t;

	typedef struct packed {
		logic [SOCK_W-1:0] socket;
		logic [1:0]        liveness;
	} slot_entry_t;

	typedef struct packed {
		logic                done;
		logic [BUDGET_W-1:0] quotient;
	} div_status_t;

endpackage

`default_nettype wire

>>> hdl/cstl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module cstl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/cstl_div.sv
// Restoring divider, one quotient bit per cycle: budget / active count.
// Depends on cstl_pkg.
`default_nettype none

module cstl_div
	import cstl_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire logic [BUDGET_W-1:0] dividend,
	input  wire logic [COUNT_W-1:0]  divisor,
	output div_status_t              status
);

	localparam int CNT_W = $clog2(BUDGET_W + 1);

	logic                run_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BUDGET_W-1:0] quo_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [COUNT_W-1:0]  dvs_q;
	logic [COUNT_W:0]    trial;
	logic [COUNT_W:0]    diff;
	logic                take;

	assign trial = {rem_q, quo_q[BUDGET_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(BUDGET_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			// zero count is taken as one
			dvs_q <= (divisor == '0) ? COUNT_W'(1) : divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[BUDGET_W-2:0], take};
			rem_q <= take ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
		end
	end

	assign status.done     = done_q;
	assign status.quotient = quo_q;

endmodule

`default_nettype wire

>>> hdl/connection_slot_table_liveness.sv
// Top level of the connection slot table: sequencer, valid bits, result register.
// Depends on cstl_pkg, cstl_ram and cstl_div.
//
//  channel  | signals                                           | handshake
//  ---------+---------------------------------------------------+-------------------------
//  command  | start, busy, action, socket_id, now_ms,           | taken when start && !busy
//           | active_count                                      |
//  result   | result_valid, hit, slot_index, table_full,        | one-cycle strobe, no stall
//           | close_connection                                  |
//  config   | cfg_valid, cfg_ready, cfg_data                    | valid && ready, always ready
//
// Connect: result strobe the cycle after the transaction (free slot taken from valid flops).
// Message, disconnect, prune: a scan reads the socket RAM one slot a cycle from slot 0 up,
// and the result follows a match, or the last slot on a miss. Prune of an ok slot also
// waits on the budget divider and the stamp RAM read. One transaction at a time; busy is
// high until the result is strobed.
// Reset clears valid bits and sequencer and presets the budget; the RAMs need no clearing.
// The receiver cannot stall results.
`default_nettype none

module connection_slot_table_liveness
	import cstl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// command
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           action,
	input  wire logic [SOCK_W-1:0]    socket_id,
	input  wire logic [TIME_W-1:0]    now_ms,
	input  wire logic [COUNT_W-1:0]   active_count,
	// result
	output logic                      result_valid,
	output logic                      hit,
	output logic [OUT_IDX_W-1:0]      slot_index,
	output logic                      table_full,
	output logic                      close_connection,
	// config
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [BUDGET_W-1:0]  cfg_data
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	cstl_state_t state_q, state_d;

	logic [BUDGET_W-1:0]   budget_q;
	logic [SLOT_COUNT-1:0] valid_q;

	// latched command
	logic [1:0]        act_q;
	logic [SOCK_W-1:0] id_q;
	logic [TIME_W-1:0] now_q;

	// scan position: slot whose RAM data is on a_rdata
	logic [IDX_W-1:0]  chk_idx_s1;
	logic [TIME_W-1:0] limit_q;

	// RAM ports
	logic              a_we, a_re;
	logic [IDX_W-1:0]  a_waddr, a_raddr;
	slot_entry_t       a_wdata, a_rdata;
	logic              b_we, b_re;
	logic [TIME_W-1:0] b_rdata;

	div_status_t div_st;
	logic        accept;
	logic        div_go;

	// free slot search
	logic             free_any;
	logic [IDX_W-1:0] free_idx;

	// combinational outputs of the sequencer
	logic             match;
	logic             scan_last;
	logic             res_fire, res_hit, res_full, res_close;
	logic [IDX_W-1:0] res_idx;
	logic             vset, vclr;
	logic [IDX_W-1:0] vidx;
	logic             dead;
	logic [TIME_W-1:0] idle_ms;

	// result register
	logic                 res_valid_q, hit_q, full_q, close_q;
	logic [IDX_W-1:0]     idx_q;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign div_go    = accept && (action == ACT_PRUNE);

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(k);
			end
		end
	end

	assign match     = valid_q[chk_idx_s1] && (a_rdata.socket == id_q);
	assign scan_last = (chk_idx_s1 == LAST_IDX);
	assign idle_ms   = now_q - b_rdata;
	assign dead      = (idle_ms > limit_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (action != ACT_CONNECT)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					if ((act_q == ACT_PRUNE) && (a_rdata.liveness != LIVE_INIT)
						&& (a_rdata.liveness != LIVE_TEST)) begin
						state_d = ST_LIMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (scan_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_LIMIT: begin
				if (div_st.done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs: RAM accesses, valid bit updates, result
	always_comb begin
		a_we      = 1'b0;
		a_waddr   = chk_idx_s1;
		a_wdata   = '{socket: id_q, liveness: LIVE_OK};
		a_re      = 1'b0;
		a_raddr   = '0;
		b_we      = 1'b0;
		b_re      = 1'b0;
		vset      = 1'b0;
		vclr      = 1'b0;
		vidx      = chk_idx_s1;
		res_fire  = 1'b0;
		res_hit   = 1'b0;
		res_idx   = '0;
		res_full  = 1'b0;
		res_close = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_CONNECT) begin
						res_fire = 1'b1;
						if (free_any) begin
							a_we     = 1'b1;
							a_waddr  = free_idx;
							a_wdata  = '{socket: socket_id, liveness: LIVE_INIT};
							vset     = 1'b1;
							vidx     = free_idx;
							res_hit  = 1'b1;
							res_idx  = free_idx;
						end else begin
							res_full = 1'b1;
						end
					end else begin
						a_re    = 1'b1;
						a_raddr = '0;
					end
				end
			end
			ST_SCAN: begin
				if (match) begin
					res_hit = 1'b1;
					res_idx = chk_idx_s1;
					case (act_q)
						ACT_MESSAGE: begin
							a_we     = 1'b1;
							b_we     = 1'b1;
							res_fire = 1'b1;
						end
						ACT_DISCONNECT: begin
							vclr     = 1'b1;
							res_fire = 1'b1;
						end
						default: begin
							case (a_rdata.liveness)
								LIVE_INIT: begin
									a_we     = 1'b1;
									a_wdata  = '{socket: id_q, liveness: LIVE_TEST};
									res_fire = 1'b1;
								end
								LIVE_TEST: begin
									vclr      = 1'b1;
									res_close = 1'b1;
									res_fire  = 1'b1;
								end
								default: begin
									// ok (and the unused code): fetch the stamp
									b_re = 1'b1;
								end
							endcase
						end
					endcase
				end else if (scan_last) begin
					res_fire = 1'b1;
				end else begin
					a_re    = 1'b1;
					a_raddr = chk_idx_s1 + IDX_W'(1);
				end
			end
			ST_LIMIT: begin
			end
			ST_CHECK: begin
				res_fire  = 1'b1;
				res_hit   = 1'b1;
				res_idx   = chk_idx_s1;
				res_close = dead;
				vclr      = dead;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			budget_q    <= BUDGET_RESET;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_fire;
			if (cfg_valid && cfg_ready) begin
				budget_q <= cfg_data;
			end
			if (vset) begin
				valid_q[vidx] <= 1'b1;
			end else if (vclr) begin
				valid_q[vidx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= action;
			id_q       <= socket_id;
			now_q      <= now_ms;
			chk_idx_s1 <= '0;
		end else if ((state_q == ST_SCAN) && a_re) begin
			chk_idx_s1 <= a_raddr;
		end
		if ((state_q == ST_LIMIT) && div_st.done) begin
			limit_q <= TIME_W'(div_st.quotient) * MS_PER_SECOND;
		end
		if (res_fire) begin
			hit_q   <= res_hit;
			idx_q   <= res_idx;
			full_q  <= res_full;
			close_q <= res_close;
		end
	end

	// socket id and liveness per slot
	cstl_ram #(
		.WIDTH ($bits(slot_entry_t)),
		.DEPTH (SLOT_COUNT)
	) u_ram_sock (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	// last-seen stamp per slot; written only by a message
	cstl_ram #(
		.WIDTH (TIME_W),
		.DEPTH (SLOT_COUNT)
	) u_ram_stamp (
		.clk   (clk),
		.we    (b_we),
		.waddr (chk_idx_s1),
		.wdata (now_q),
		.re    (b_re),
		.raddr (chk_idx_s1),
		.rdata (b_rdata)
	);

	// budget / active count, started with every prune transaction
	cstl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (budget_q),
		.divisor  (active_count),
		.status   (div_st)
	);

	assign result_valid     = res_valid_q;
	assign hit              = hit_q;
	assign slot_index       = OUT_IDX_W'(idx_q);
	assign table_full       = full_q;
	assign close_connection = close_q;

endmodule

`default_nettype wire

>>> sim/cstl_tracker_pkg.sv
// Scoreboard for the connection slot table: a slot table tracker that predicts each
// command's outcome and checks the strobed results in order. Depends on cstl_pkg.
`default_nettype none

package cstl_tracker_pkg;

	import cstl_pkg::*;

	typedef struct packed {
		logic                 hit;
		logic [OUT_IDX_W-1:0] slot_index;
		logic                 table_full;
		logic                 close_connection;
	} slot_outcome_t;

	class slot_table_tracker;

		bit                  slot_valid[SLOT_COUNT];
		logic [1:0]          slot_liveness[SLOT_COUNT];
		logic [SOCK_W-1:0]   slot_socket[SLOT_COUNT];
		logic [TIME_W-1:0]   slot_last_seen[SLOT_COUNT];
		logic [BUDGET_W-1:0] budget_seconds;
		slot_outcome_t       outcomes[$];
		int                  mismatch_count;

		function new();
			budget_seconds = BUDGET_RESET;
			mismatch_count = 0;
			for (int k = 0; k < SLOT_COUNT; k++) begin
				slot_valid[k]     = 1'b0;
				slot_liveness[k]  = LIVE_INIT;
				slot_socket[k]    = '0;
				slot_last_seen[k] = '0;
			end
		endfunction

		function void set_budget(logic [BUDGET_W-1:0] value);
			budget_seconds = value;
		endfunction

		function int pending();
			return outcomes.size();
		endfunction

		function int live_count();
			int n;
			n = 0;
			for (int k = 0; k < SLOT_COUNT; k++)
				if (slot_valid[k]) n++;
			return n;
		endfunction

		// socket id of the pick-th occupied slot
		function logic [SOCK_W-1:0] live_socket(int pick);
			int n;
			n = 0;
			for (int k = 0; k < SLOT_COUNT; k++) begin
				if (slot_valid[k]) begin
					if (n == pick) return slot_socket[k];
					n++;
				end
			end
			return '0;
		endfunction

		function slot_outcome_t predict_outcome(logic [1:0] act, logic [SOCK_W-1:0] id,
				logic [TIME_W-1:0] now, logic [COUNT_W-1:0] count);
			slot_outcome_t       r;
			int                  found;
			logic [TIME_W-1:0]   limit_ms;
			logic [TIME_W-1:0]   idle_ms;
			logic [COUNT_W-1:0]  divisor;
			logic                alive;
			r     = '0;
			found = -1;
			if (act == ACT_CONNECT) begin
				// lowest free slot; duplicates of an existing id are allowed
				for (int k = 0; k < SLOT_COUNT; k++)
					if (found < 0 && !slot_valid[k]) found = k;
				if (found < 0) begin
					r.table_full = 1'b1;
				end else begin
					slot_valid[found]    = 1'b1;
					slot_socket[found]   = id;
					slot_liveness[found] = LIVE_INIT;
					r.hit        = 1'b1;
					r.slot_index = OUT_IDX_W'(found);
				end
			end else begin
				for (int k = 0; k < SLOT_COUNT; k++)
					if (found < 0 && slot_valid[k] && slot_socket[k] == id) found = k;
				if (found >= 0) begin
					r.hit        = 1'b1;
					r.slot_index = OUT_IDX_W'(found);
					if (act == ACT_MESSAGE) begin
						slot_liveness[found]  = LIVE_OK;
						slot_last_seen[found] = now;
					end else if (act == ACT_DISCONNECT) begin
						slot_valid[found] = 1'b0;
					end else begin
						alive = 1'b1;
						case (slot_liveness[found])
							LIVE_INIT: slot_liveness[found] = LIVE_TEST;
							LIVE_TEST: alive = 1'b0;
							default: begin
								// ok (and the unused fourth code): idle time vs budget share
								divisor  = (count == '0) ? COUNT_W'(1) : count;
								limit_ms = (TIME_W'(budget_seconds) / TIME_W'(divisor))
									* MS_PER_SECOND;
								idle_ms  = now - slot_last_seen[found];
								if (idle_ms > limit_ms) alive = 1'b0;
							end
						endcase
						if (!alive) begin
							slot_valid[found]  = 1'b0;
							r.close_connection = 1'b1;
						end
					end
				end
			end
			return r;
		endfunction

		function void note_command(logic [1:0] act, logic [SOCK_W-1:0] id,
				logic [TIME_W-1:0] now, logic [COUNT_W-1:0] count);
			outcomes.push_back(predict_outcome(act, id, now, count));
		endfunction

		function void check_result(logic got_hit, logic [OUT_IDX_W-1:0] got_index,
				logic got_full, logic got_close);
			slot_outcome_t want;
			if (outcomes.size() == 0) begin
				$error("unexpected result: no command outstanding");
				mismatch_count++;
				return;
			end
			want = outcomes.pop_front();
			if (got_hit !== want.hit) begin
				$error("hit: expected %0d, actual %0d", want.hit, got_hit);
				mismatch_count++;
			end
			if (got_index !== want.slot_index) begin
				$error("slot_index: expected %0d, actual %0d", want.slot_index, got_index);
				mismatch_count++;
			end
			if (got_full !== want.table_full) begin
				$error("table_full: expected %0d, actual %0d", want.table_full, got_full);
				mismatch_count++;
			end
			if (got_close !== want.close_connection) begin
				$error("close_connection: expected %0d, actual %0d",
					want.close_connection, got_close);
				mismatch_count++;
			end
		endfunction

	endclass

endpackage

`default_nettype wire

>>> sim/connection_slot_table_liveness_test.sv
// Self-checking testbench for connection_slot_table_liveness: directed and random
// command streams, result checking through the slot table tracker.
// Depends on cstl_pkg and cstl_tracker_pkg.
`default_nettype none

module connection_slot_table_liveness_test;

	timeunit 1ns;
	timeprecision 1ps;

	import cstl_pkg::*;
	import cstl_tracker_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 90;
	localparam int TIMEOUT_NS    = 5_000_000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          action;
	logic [SOCK_W-1:0]   socket_id;
	logic [TIME_W-1:0]   now_ms;
	logic [COUNT_W-1:0]  active_count;
	logic                result_valid;
	logic                hit;
	logic [OUT_IDX_W-1:0] slot_index;
	logic                table_full;
	logic                close_connection;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [BUDGET_W-1:0] cfg_data;

	slot_table_tracker tracker = new();

	// running millisecond clock for the random part; wraps like the real one
	logic [TIME_W-1:0] wall_ms;

	connection_slot_table_liveness uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.socket_id        (socket_id),
		.now_ms           (now_ms),
		.active_count     (active_count),
		.result_valid     (result_valid),
		.hit              (hit),
		.slot_index       (slot_index),
		.table_full       (table_full),
		.close_connection (close_connection),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result monitor: the strobe lasts one cycle and cannot be stalled, so every
	// edge with result_valid high is a transaction.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1)
			tracker.check_result(hit, slot_index, table_full, close_connection);
	end

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one command and hold it until the block takes it (start && !busy).
	// start stays high on return so a following command can go out back to back.
	task automatic send_command(input logic [1:0] act, input logic [SOCK_W-1:0] id,
			input logic [TIME_W-1:0] stamp, input logic [COUNT_W-1:0] count);
		start        <= 1'b1;
		action       <= act;
		socket_id    <= id;
		now_ms       <= stamp;
		active_count <= count;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_command(act, id, stamp, count);
	endtask

	// Send, then idle the command side for a random number of cycles unless steady.
	task automatic issue_command(input logic [1:0] act, input logic [SOCK_W-1:0] id,
			input logic [TIME_W-1:0] stamp, input logic [COUNT_W-1:0] count,
			input bit steady);
		int unsigned gap;
		send_command(act, id, stamp, count);
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has been strobed.
	task automatic wait_for_drain();
		start <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0 || busy !== 1'b0);
	endtask

	// Budget register write; only called while the block is idle.
	task automatic write_budget(input logic [BUDGET_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		tracker.set_budget(value);
		cfg_valid <= 1'b0;
	endtask

	// Random traffic. Most lookups target an occupied slot so that the liveness
	// ladder (init -> test -> dead, message -> ok, ok timing out) is exercised;
	// the rest are misses, stray ids and arbitrary timestamps.
	task automatic run_random_phase(input int unsigned items, input bit steady);
		logic [1:0]         act;
		logic [SOCK_W-1:0]  id;
		logic [COUNT_W-1:0] count;
		int unsigned        r;
		int unsigned        step_max;
		int                 live;
		// time advance scaled to the budget so ok slots both survive and expire
		step_max = (int'(tracker.budget_seconds) * 1000) / 16 + 1;
		repeat (items) begin
			r = $urandom_range(0, 99);
			if (r < 30)      act = ACT_CONNECT;
			else if (r < 60) act = ACT_MESSAGE;
			else if (r < 70) act = ACT_DISCONNECT;
			else             act = ACT_PRUNE;

			live = tracker.live_count();
			if (act != ACT_CONNECT && live > 0 && $urandom_range(0, 4) != 0)
				id = tracker.live_socket($urandom_range(0, live - 1));
			else if ($urandom_range(0, 3) == 0)
				id = SOCK_W'($urandom);
			else
				id = SOCK_W'($urandom_range(0, 31));

			r = $urandom_range(0, 99);
			if (r < 10)       wall_ms = $urandom;
			else if (r >= 25) wall_ms = wall_ms + TIME_W'($urandom_range(0, step_max));

			if ($urandom_range(0, 99) < 70) count = COUNT_W'($urandom_range(1, 8));
			else                            count = COUNT_W'($urandom_range(0, 255));

			issue_command(act, id, wall_ms, count, steady);
			// occasional full drain mid-stream
			if ($urandom_range(0, 49) == 0) wait_for_drain();
		end
	endtask

	initial begin
		logic [BUDGET_W-1:0] phase_budget;

		arst_n       <= 1'b0;
		start        <= 1'b0;
		action       <= ACT_CONNECT;
		socket_id    <= '0;
		now_ms       <= '0;
		active_count <= '0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		wall_ms       = $urandom;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, budget at its reset value (600 s) ----
		// lookups on an empty table miss
		issue_command(ACT_MESSAGE, 8'd5, 32'd0, 8'd1, 1'b0);
		issue_command(ACT_PRUNE, 8'd5, 32'd0, 8'd1, 1'b0);
		// fill every slot, extremes of the id among them; one more connect is rejected
		issue_command(ACT_CONNECT, 8'd0, 32'd0, 8'd1, 1'b0);
		issue_command(ACT_CONNECT, 8'd255, 32'd0, 8'd1, 1'b0);
		for (int k = 2; k < SLOT_COUNT; k++)
			issue_command(ACT_CONNECT, SOCK_W'(k), 32'd0, 8'd1, 1'b0);
		issue_command(ACT_CONNECT, 8'd77, 32'd0, 8'd1, 1'b0);
		// prune walks init -> test, then test is dead and the slot is freed
		issue_command(ACT_PRUNE, 8'd255, 32'd0, 8'd1, 1'b0);
		issue_command(ACT_PRUNE, 8'd255, 32'd0, 8'd1, 1'b0);
		// freed slot 1 is the lowest free one again
		issue_command(ACT_CONNECT, 8'd200, 32'd0, 8'd1, 1'b0);
		// stamp at the top of the time range; zero active count counts as one, so the
		// limit is 600000 ms: idle exactly at the limit across the wrap stays alive,
		// one more millisecond is dead
		issue_command(ACT_MESSAGE, 8'd0, 32'hFFFF_FFFF, 8'd1, 1'b0);
		issue_command(ACT_PRUNE, 8'd0, 32'h0009_27BF, 8'd0, 1'b0);
		issue_command(ACT_PRUNE, 8'd0, 32'h0009_27C0, 8'd1, 1'b0);
		issue_command(ACT_DISCONNECT, 8'd200, 32'd0, 8'd1, 1'b0);
		issue_command(ACT_DISCONNECT, 8'd200, 32'd0, 8'd1, 1'b0);
		// largest active count shrinks the share to 2000 ms
		issue_command(ACT_MESSAGE, 8'd2, 32'd0, 8'd255, 1'b0);
		issue_command(ACT_PRUNE, 8'd2, 32'd1999, 8'd255, 1'b0);
		issue_command(ACT_PRUNE, 8'd2, 32'd3000, 8'd255, 1'b0);

		// ---- random phases, budget rewritten while idle between them ----
		for (int p = 0; p < 5; p++) begin
			case (p)
				0:       phase_budget = BUDGET_W'(1);
				1:       phase_budget = '1;
				2:       phase_budget = BUDGET_W'($urandom_range(1, 65535));
				3:       phase_budget = BUDGET_W'($urandom_range(2, 40));
				default: phase_budget = BUDGET_RESET;
			endcase
			wait_for_drain();
			write_budget(phase_budget);
			// phase 1 runs with no random idle gaps between commands
			run_random_phase(PHASE_ITEMS, p == 1);
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (tracker.mismatch_count == 0 && tracker.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
hdl/cstl_pkg.sv
hdl/cstl_ram.sv
hdl/cstl_div.sv
hdl/connection_slot_table_liveness.sv
sim/cstl_tracker_pkg.sv
sim/connection_slot_table_liveness_test.sv
